// ===== sv/dpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpsc_pkg
// types and constants shared by the dual-axle pi steering controller
// ----------------------------------------------------------------------------
package dpsc_pkg;

  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 39;

  localparam int KP_W      = 16;
  localparam int KI_W      = 24;
  localparam int ILIM_W    = 39;
  localparam int OLIM_W    = 15;
  localparam int SCALE_W   = 16;
  localparam int PERIOD_W  = 16;
  localparam int ELAPSED_W = 16;
  localparam int STEER_W   = 16;

  // shared multiplier: wide operand taken in two 32 bit chunks
  localparam int MUL_W = 32;
  localparam int MOP_W = 2 * MUL_W;
  localparam int ACC_W = MOP_W + MUL_W;

  // gain and scaled gain saturate at 2^40
  localparam int              SAT_W   = 41;
  localparam logic [SAT_W-1:0] SAT_VAL = {1'b1, {(SAT_W-1){1'b0}}};

  localparam int KP_SHIFT = 8;
  localparam int KT_SHIFT = 20;
  localparam int P_SHIFT  = 24;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_RESET  = 2'd2
  } op_e;

  localparam logic [CFG_IDX_W-1:0] CFG_KP        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd5;

  localparam logic [KP_W-1:0]     KP_RST     = 16'd77;
  localparam logic [KI_W-1:0]     KI_RST     = 24'd0;
  localparam logic [ILIM_W-1:0]   ILIM_RST   = 39'd0;
  localparam logic [OLIM_W-1:0]   OLIM_RST   = 15'd1430;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 16'd894;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd100;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_IMUL   = 10'b0000000010,
    S_ICLAMP = 10'b0000000100,
    S_KMUL   = 10'b0000001000,
    S_GAIN   = 10'b0000010000,
    S_MMUL   = 10'b0000100000,
    S_MSAT   = 10'b0001000000,
    S_PMUL   = 10'b0010000000,
    S_ANGLE  = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_e;

endpackage

// ===== sv/dpsc_in_if.sv =====
// ----------------------------------------------------------------------------
// dpsc_in_if
// input item channel: op code and the two axle errors
// ----------------------------------------------------------------------------
interface dpsc_in_if
  import dpsc_pkg::*;
#(
  parameter int ErrWidth = 16
);
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            op;
  logic signed [ErrWidth-1:0] err_front;
  logic signed [ErrWidth-1:0] err_rear;

  modport source (output valid, op, err_front, err_rear, input ready);
  modport sink (input valid, op, err_front, err_rear, output ready);
endinterface

// ===== sv/dpsc_out_if.sv =====
// ----------------------------------------------------------------------------
// dpsc_out_if
// result item channel: update flag and the two steering angles
// ----------------------------------------------------------------------------
interface dpsc_out_if
  import dpsc_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      updated;
  logic signed [STEER_W-1:0] steer_front;
  logic signed [STEER_W-1:0] steer_rear;

  modport source (output valid, updated, steer_front, steer_rear, input ready);
  modport sink (input valid, updated, steer_front, steer_rear, output ready);
endinterface

// ===== sv/dual_pi_steering_controller.sv =====
// ----------------------------------------------------------------------------
// dual_pi_steering_controller
// two-channel pi steering controller with integrator and output clamps
// ----------------------------------------------------------------------------
// channel   dir   handshake           payload
// in_i      in    valid / ready       op, err_front, err_rear
// out_o     out   valid / ready       updated, steer_front, steer_rear
// cfg       in    cfg_we_i            cfg_idx_i, cfg_wdata_i
//
// tick, reset and unused op items are taken in idle and give no result
// a sample request that is not yet due gives a zero, non-updated result
// an updating sample request runs, per axle, four products on the
// one 32x32 multiplier, each in two passes, plus clamp, gain, saturate, angle
// the output register frees the input side while a result waits for ready
// asynchronous active-low reset restores register defaults and clears state
// ----------------------------------------------------------------------------
module dual_pi_steering_controller
  import dpsc_pkg::*;
#(
  parameter int ERR_WIDTH   = 16,
  parameter int INTEG_WIDTH = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dpsc_in_if.sink               in_i,
  dpsc_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int EW       = ERR_WIDTH;
  localparam int IW       = INTEG_WIDTH;
  localparam int PROD_W   = ELAPSED_W + EW;
  localparam int DELTA_W  = PROD_W + 1;
  localparam int SUM_W    = ((IW > DELTA_W) ? IW : DELTA_W) + 1;
  localparam int KT_W     = KI_W + IW - 1 - KT_SHIFT;
  localparam int KPQ_W    = KP_W + KP_SHIFT;
  localparam int GM_W     = ((KT_W > KPQ_W) ? KT_W : KPQ_W) + 1;
  localparam int CMP_W    = (GM_W > SAT_W) ? GM_W : SAT_W;
  localparam int PF_W     = ACC_W - P_SHIFT;
  localparam logic [63:0] INTEG_CAP = (64'd1 << (IW - 1)) - 64'd1;

  // configuration
  logic [KP_W-1:0]     kp_q;
  logic [KI_W-1:0]     ki_q;
  logic [ILIM_W-1:0]   ilim_q;
  logic [OLIM_W-1:0]   olim_q;
  logic [SCALE_W-1:0]  scale_q;
  logic [PERIOD_W-1:0] period_q;

  // control and architectural state
  state_e               state_q, state_d;
  logic                 k_q, k_d;
  logic                 ch_q, ch_d;
  logic                 out_valid_q, out_valid_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic signed [IW-1:0] integ_f_q, integ_f_d;
  logic signed [IW-1:0] integ_r_q, integ_r_d;

  // datapath
  logic signed [EW-1:0]      err_f_q, err_f_d;
  logic signed [EW-1:0]      err_r_q, err_r_d;
  logic [ACC_W-1:0]          acc_q, acc_d;
  logic [SAT_W-1:0]          gm_q, gm_d;
  logic [SAT_W-1:0]          m_q, m_d;
  logic                      neg_q, neg_d;
  logic                      res_upd_q, res_upd_d;
  logic signed [STEER_W-1:0] res_f_q, res_f_d;
  logic signed [STEER_W-1:0] res_r_q, res_r_d;
  logic                      out_upd_q, out_upd_d;
  logic signed [STEER_W-1:0] out_f_q, out_f_d;
  logic signed [STEER_W-1:0] out_r_q, out_r_d;

  // channel operands
  logic signed [EW-1:0]  cur_err;
  logic signed [IW-1:0]  cur_integ;
  logic                  err_neg;
  logic [EW-1:0]         em;
  logic [IW-1:0]         integ_abs;

  // shared multiplier
  logic [MOP_W-1:0]      a_op;
  logic [MUL_W-1:0]      b_op;
  logic [MUL_W-1:0]      a_chunk;
  logic [MOP_W-1:0]      prod;
  logic [ACC_W-1:0]      mul_acc;

  // integrator clamp
  logic [63:0]              lim64;
  logic [IW-2:0]            lim;
  logic signed [DELTA_W-1:0] delta;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  lim_pos;
  logic signed [SUM_W-1:0]  lim_neg;
  logic signed [IW-1:0]     integ_new;

  // gain and angle
  logic [KT_W-1:0]       kt;
  logic [KPQ_W-1:0]      kpq;
  logic                  kt_gt;
  logic [GM_W-1:0]       gm;
  logic                  gain_neg;
  logic [PF_W-1:0]       p_full;
  logic [OLIM_W-1:0]     p_mag;
  logic signed [STEER_W-1:0] steer;

  assign cur_err   = ch_q ? err_r_q : err_f_q;
  assign cur_integ = ch_q ? integ_r_q : integ_f_q;
  assign err_neg   = cur_err[EW-1];
  assign em        = err_neg ? EW'(-cur_err) : EW'(cur_err);
  assign integ_abs = cur_integ[IW-1] ? IW'(-cur_integ) : IW'(cur_integ);

  always_comb begin
    case (state_q)
      S_IMUL: begin
        a_op = MOP_W'(elapsed_q);
        b_op = MUL_W'(em);
      end
      S_KMUL: begin
        a_op = MOP_W'(integ_abs);
        b_op = MUL_W'(ki_q);
      end
      S_MMUL: begin
        a_op = MOP_W'(gm_q);
        b_op = MUL_W'(scale_q);
      end
      S_PMUL: begin
        a_op = MOP_W'(m_q);
        b_op = MUL_W'(em);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign a_chunk = k_q ? a_op[MOP_W-1:MUL_W] : a_op[MUL_W-1:0];
  assign prod    = MOP_W'(a_chunk) * MOP_W'(b_op);
  assign mul_acc = k_q ? (acc_q + {prod, {MUL_W{1'b0}}}) : ACC_W'(prod);

  // integrator update with clamp
  assign lim64   = (64'(ilim_q) > INTEG_CAP) ? INTEG_CAP : 64'(ilim_q);
  assign lim     = lim64[IW-2:0];
  assign delta   = err_neg ? -$signed({1'b0, acc_q[PROD_W-1:0]})
                           : $signed({1'b0, acc_q[PROD_W-1:0]});
  assign sum     = SUM_W'(cur_integ) + SUM_W'(delta);
  assign lim_pos = $signed(SUM_W'(lim));
  assign lim_neg = -lim_pos;

  always_comb begin
    if (sum > lim_pos) begin
      integ_new = IW'(lim_pos);
    end else if (sum < lim_neg) begin
      integ_new = IW'(lim_neg);
    end else begin
      integ_new = IW'(sum);
    end
  end

  // gain magnitude and sign
  assign kt    = acc_q[KT_SHIFT+KT_W-1:KT_SHIFT];
  assign kpq   = {kp_q, {KP_SHIFT{1'b0}}};
  assign kt_gt = GM_W'(kt) > GM_W'(kpq);

  always_comb begin
    if (!cur_integ[IW-1]) begin
      gm = GM_W'(kpq) + GM_W'(kt);
    end else if (kt_gt) begin
      gm = GM_W'(kt) - GM_W'(kpq);
    end else begin
      gm = GM_W'(kpq) - GM_W'(kt);
    end
  end

  assign gain_neg = cur_integ[IW-1] && kt_gt;

  // angle magnitude, clamp and sign
  assign p_full = acc_q[ACC_W-1:P_SHIFT];
  assign p_mag  = (p_full > PF_W'(olim_q)) ? olim_q : p_full[OLIM_W-1:0];
  assign steer  = (neg_q && (p_mag != '0)) ? -$signed({1'b0, p_mag})
                                           : $signed({1'b0, p_mag});

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q;
    elapsed_d   = elapsed_q;
    integ_f_d   = integ_f_q;
    integ_r_d   = integ_r_q;
    err_f_d     = err_f_q;
    err_r_d     = err_r_q;
    acc_d       = acc_q;
    gm_d        = gm_q;
    m_d         = m_q;
    neg_d       = neg_q;
    res_upd_d   = res_upd_q;
    res_f_d     = res_f_q;
    res_r_d     = res_r_q;
    out_upd_d   = out_upd_q;
    out_f_d     = out_f_q;
    out_r_d     = out_r_q;

    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          err_f_d = in_i.err_front;
          err_r_d = in_i.err_rear;
          if (in_i.op == OP_TICK) begin
            if (elapsed_q != '1) begin
              elapsed_d = elapsed_q + ELAPSED_W'(1);
            end
          end else if (in_i.op == OP_RESET) begin
            elapsed_d = '0;
            integ_f_d = '0;
            integ_r_d = '0;
          end else if (in_i.op == OP_SAMPLE) begin
            ch_d = 1'b0;
            k_d  = 1'b0;
            if (elapsed_q >= period_q) begin
              state_d = S_IMUL;
            end else begin
              res_upd_d = 1'b0;
              res_f_d   = '0;
              res_r_d   = '0;
              state_d   = S_OUT;
            end
          end
        end
      end
      S_IMUL, S_KMUL, S_MMUL, S_PMUL: begin
        acc_d = mul_acc;
        k_d   = !k_q;
        if (k_q) begin
          case (state_q)
            S_IMUL:  state_d = S_ICLAMP;
            S_KMUL:  state_d = S_GAIN;
            S_MMUL:  state_d = S_MSAT;
            default: state_d = S_ANGLE;
          endcase
        end
      end
      S_ICLAMP: begin
        if (ch_q) begin
          integ_r_d = integ_new;
        end else begin
          integ_f_d = integ_new;
        end
        state_d = S_KMUL;
      end
      S_GAIN: begin
        gm_d    = (CMP_W'(gm) > CMP_W'(SAT_VAL)) ? SAT_VAL : SAT_W'(gm);
        neg_d   = gain_neg ^ err_neg;
        state_d = S_MMUL;
      end
      S_MSAT: begin
        m_d     = (acc_q > ACC_W'(SAT_VAL)) ? SAT_VAL : acc_q[SAT_W-1:0];
        state_d = S_PMUL;
      end
      S_ANGLE: begin
        if (ch_q) begin
          res_r_d   = steer;
          res_upd_d = 1'b1;
          elapsed_d = '0;
          ch_d      = 1'b0;
          state_d   = S_OUT;
        end else begin
          res_f_d = steer;
          ch_d    = 1'b1;
          state_d = S_IMUL;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_upd_d   = res_upd_q;
          out_f_d     = res_f_q;
          out_r_d     = res_r_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        k_d     = 1'b0;
        ch_d    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= 1'b0;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
      elapsed_q   <= '0;
      integ_f_q   <= '0;
      integ_r_q   <= '0;
      kp_q        <= KP_RST;
      ki_q        <= KI_RST;
      ilim_q      <= ILIM_RST;
      olim_q      <= OLIM_RST;
      scale_q     <= SCALE_RST;
      period_q    <= PERIOD_RST;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
      elapsed_q   <= elapsed_d;
      integ_f_q   <= integ_f_d;
      integ_r_q   <= integ_r_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KP:        kp_q     <= cfg_wdata_i[KP_W-1:0];
          CFG_KI:        ki_q     <= cfg_wdata_i[KI_W-1:0];
          CFG_INTEG_LIM: ilim_q   <= cfg_wdata_i[ILIM_W-1:0];
          CFG_OUT_LIM:   olim_q   <= cfg_wdata_i[OLIM_W-1:0];
          CFG_ERR_SCALE: scale_q  <= cfg_wdata_i[SCALE_W-1:0];
          CFG_PERIOD:    period_q <= cfg_wdata_i[PERIOD_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    err_f_q   <= err_f_d;
    err_r_q   <= err_r_d;
    acc_q     <= acc_d;
    gm_q      <= gm_d;
    m_q       <= m_d;
    neg_q     <= neg_d;
    res_upd_q <= res_upd_d;
    res_f_q   <= res_f_d;
    res_r_q   <= res_r_d;
    out_upd_q <= out_upd_d;
    out_f_q   <= out_f_d;
    out_r_q   <= out_r_d;
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.updated     = out_upd_q;
  assign out_o.steer_front = out_f_q;
  assign out_o.steer_rear  = out_r_q;

  // a new result only ever comes from the output stage
  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result appeared without passing the output stage");

  // every product takes exactly two passes of the multiplier
  a_mul_two_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_IMUL || state_q == S_KMUL || state_q == S_MMUL ||
      state_q == S_PMUL) && k_q) |=> (state_q != $past(state_q)))
    else $error("multiply did not advance after its second pass");

  // the rear axle is only selected inside a computation
  a_ch_front_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_OUT) |-> !ch_q)
    else $error("axle select left on rear outside a computation");

endmodule
